### design/narp_pkg.sv
// ----------------------------------------------------------------------------
// narp_pkg
// Shared types, codes and constants of the note arpeggiator.
// ----------------------------------------------------------------------------
`default_nettype none

package narp_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_HELD_DEF    = 16;
  localparam int MAX_OCTAVES_DEF = 4;
  localparam int PHASE_BITS_DEF  = 32;

  // Fixed field widths
  localparam int NOTE_W      = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int PATTERN_W   = 3;
  localparam int OCTAVE_W    = 3;
  localparam int GATE_W      = 17;
  localparam int LFSR_W      = 16;

  // Musical constants
  localparam int SEMITONES = 12;
  localparam int NOTE_TOP  = 127;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_CLEAR    = 2'd3
  } narp_op_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NOTE_ON  = 2'd1,
    EV_GATE_OFF = 2'd2
  } narp_event_t;

  typedef enum logic [PATTERN_W-1:0] {
    PAT_UP     = 3'd0,
    PAT_DOWN   = 3'd1,
    PAT_UPDOWN = 3'd2,
    PAT_PLAYED = 3'd3,
    PAT_RANDOM = 3'd4
  } narp_pattern_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE          = 3'd0,
    REG_PATTERN_MODE    = 3'd1,
    REG_OCTAVE_COUNT    = 3'd2,
    REG_PHASE_INCREMENT = 3'd3,
    REG_GATE_LENGTH     = 3'd4
  } narp_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV,
    ST_ELEM_RD,
    ST_ELEM_DATA,
    ST_ON_SCAN,
    ST_ON_SHIFT,
    ST_OFF_PASS,
    ST_RESEAT,
    ST_DONE
  } narp_state_t;

  // Sequencer to phase unit
  typedef struct packed {
    logic tick_go;
    logic clear;
    logic release_gate;
  } narp_phase_cmd_t;

  // Phase unit to sequencer
  typedef struct packed {
    logic wrap;
    logic gate_fire;
  } narp_tick_t;

endpackage

`default_nettype wire

### design/narp_ram.sv
// ----------------------------------------------------------------------------
// narp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module narp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/narp_phase.sv
// ----------------------------------------------------------------------------
// narp_phase
// Step phase accumulator and gate phase with gate-off detection.
// ----------------------------------------------------------------------------
`default_nettype none

module narp_phase import narp_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CFG_DATA_W-1:0] phase_increment,
  input  wire logic [GATE_W-1:0]     gate_length,
  input  wire narp_phase_cmd_t       cmd,
  output narp_tick_t                 tick
);

  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [PHASE_BITS:0]   gate_r, gate_nxt;
  logic                  closed_r, closed_nxt;

  logic [PHASE_BITS-1:0] inc;
  logic [PHASE_BITS:0]   sum;
  logic [PHASE_BITS+1:0] gsum;
  logic [PHASE_BITS:0]   gsat;
  logic [PHASE_BITS:0]   thr;
  logic                  fire;

  // Advance both phases, saturate the gate phase, compare against the gate
  always_comb begin
    inc  = PHASE_BITS'(phase_increment);
    sum  = {1'b0, step_r} + {1'b0, inc};
    gsum = {1'b0, gate_r} + (PHASE_BITS+2)'(inc);
    gsat = gsum[PHASE_BITS+1] ? '1 : gsum[PHASE_BITS:0];
    thr  = (PHASE_BITS+1)'(gate_length[GATE_W-2:0]) << (PHASE_BITS - 16);
    fire = !closed_r && !gate_length[GATE_W-1] && (gsat >= thr);

    tick.wrap      = cmd.tick_go && sum[PHASE_BITS];
    tick.gate_fire = cmd.tick_go && !sum[PHASE_BITS] && fire;

    step_nxt   = step_r;
    gate_nxt   = gate_r;
    closed_nxt = closed_r;
    if (cmd.clear) begin
      step_nxt   = '0;
      gate_nxt   = '0;
      closed_nxt = 1'b0;
    end else if (cmd.tick_go) begin
      step_nxt = sum[PHASE_BITS-1:0];
      if (sum[PHASE_BITS]) begin
        gate_nxt   = '0;
        closed_nxt = 1'b0;
      end else begin
        gate_nxt   = gsat;
        closed_nxt = closed_r | fire;
      end
    end else if (cmd.release_gate) begin
      closed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      gate_r   <= '0;
      closed_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      gate_r   <= gate_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

`default_nettype wire

### design/narp_ctrl.sv
// ----------------------------------------------------------------------------
// narp_ctrl
// Transaction sequencer: held-list passes over the two note memories,
// walk position update, small quotient unit and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module narp_ctrl import narp_pkg::*; #(
  parameter int MAX_HELD    = MAX_HELD_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1,
  localparam int CW = $clog2(MAX_HELD + 1),
  localparam int OW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1,
  localparam int UW = $clog2(MAX_OCTAVES + 1),
  localparam int LW = $clog2(MAX_HELD * MAX_OCTAVES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [NOTE_W-1:0]    in_note_number,
  input  wire logic [NOTE_W-1:0]    in_velocity,
  // result channel
  output logic                      out_strobe,
  output logic [1:0]                out_event_kind,
  output logic [NOTE_W-1:0]         out_note,
  output logic [NOTE_W-1:0]         out_velocity,
  // configuration
  input  wire logic                 cfg_enable,
  input  wire logic [PATTERN_W-1:0] cfg_pattern,
  input  wire logic [OCTAVE_W-1:0]  cfg_octaves,
  // phase unit
  output narp_phase_cmd_t           phase_cmd,
  input  wire narp_tick_t           tick,
  // arrival list memory
  output logic                      a_we,
  output logic [IW-1:0]             a_waddr,
  output logic [NOTE_W-1:0]         a_wdata,
  output logic [IW-1:0]             a_raddr,
  input  wire logic [NOTE_W-1:0]    a_rdata,
  // sorted list memory
  output logic                      s_we,
  output logic [IW-1:0]             s_waddr,
  output logic [NOTE_W-1:0]         s_wdata,
  output logic [IW-1:0]             s_raddr,
  input  wire logic [NOTE_W-1:0]    s_rdata
);

  narp_state_t         state_r, state_nxt;
  narp_op_t            op_r, op_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic [CW-1:0]       held_r, held_nxt;
  logic [OW-1:0]       oct_r, oct_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic                up_r, up_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [NOTE_W-1:0]   vel_r, vel_nxt;
  logic [LW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       end_r, end_nxt;
  logic                dv_r, dv_nxt;
  logic [CW-1:0]       didx_r, didx_nxt;
  logic                dup_r, dup_nxt;
  logic [CW-1:0]       ins_r, ins_nxt;
  logic [NOTE_W-1:0]   carry_r, carry_nxt;
  logic                found_a_r, found_a_nxt;
  logic                found_s_r, found_s_nxt;
  logic [LW-1:0]       rem_r, rem_nxt;
  logic [OW-1:0]       q_r, q_nxt;
  logic                pick_r, pick_nxt;
  logic [OW-1:0]       el_oct_r, el_oct_nxt;
  logic [IW-1:0]       el_pos_r, el_pos_nxt;
  narp_event_t         kind_r, kind_nxt;
  logic [NOTE_W-1:0]   onote_r, onote_nxt;

  logic [UW-1:0]       oc;
  logic [LW-1:0]       len;
  logic [LW-1:0]       k_now;
  logic                in_range;
  logic [OW-1:0]       eo;
  logic [IW-1:0]       en;
  logic                p_last, o_last, k_zero;
  logic [OW-1:0]       inc_oct;
  logic [IW-1:0]       inc_pos;
  logic [LFSR_W-1:0]   lfsr_step;
  logic [LFSR_W+LW-1:0] prod;
  logic [NOTE_W-1:0]   base;
  logic [NOTE_W:0]     nsum;
  logic                issuing;
  logic                pass_done;
  logic [CW-1:0]       didx_dec;

  // Octaves in use and sequence length
  always_comb begin
    if (cfg_octaves == '0) begin
      oc = UW'(1);
    end else if (32'(cfg_octaves) > MAX_OCTAVES) begin
      oc = UW'(MAX_OCTAVES);
    end else begin
      oc = UW'(cfg_octaves);
    end
    len = LW'(held_r) * LW'(oc);
  end

  // Walk position helpers
  always_comb begin
    k_now     = LW'(oct_r) * LW'(held_r) + LW'(pos_r);
    in_range  = LW'(oct_r) < LW'(oc);
    eo        = in_range ? oct_r : '0;
    en        = in_range ? pos_r : '0;
    p_last    = CW'(en) == (held_r - CW'(1));
    o_last    = LW'(eo) == (LW'(oc) - LW'(1));
    k_zero    = (eo == '0) && (en == '0);
    if (!p_last) begin
      inc_oct = eo;
      inc_pos = en + IW'(1);
    end else if (!o_last) begin
      inc_oct = eo + OW'(1);
      inc_pos = '0;
    end else begin
      inc_oct = '0;
      inc_pos = '0;
    end
    lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};
    prod      = (LFSR_W+LW)'(lfsr_step) * (LFSR_W+LW)'(len);
    base      = (narp_pattern_t'(cfg_pattern) == PAT_PLAYED) ? a_rdata : s_rdata;
    nsum      = {1'b0, base} + (NOTE_W+1)'(el_oct_r) * (NOTE_W+1)'(SEMITONES);
    issuing   = idx_r < end_r;
    pass_done = !issuing && !dv_r;
    didx_dec  = didx_r - CW'(1);
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    note_nxt    = note_r;
    held_nxt    = held_r;
    oct_nxt     = oct_r;
    pos_nxt     = pos_r;
    up_nxt      = up_r;
    lfsr_nxt    = lfsr_r;
    vel_nxt     = vel_r;
    k_nxt       = k_r;
    idx_nxt     = idx_r;
    end_nxt     = end_r;
    dv_nxt      = 1'b0;
    didx_nxt    = didx_r;
    dup_nxt     = dup_r;
    ins_nxt     = ins_r;
    carry_nxt   = carry_r;
    found_a_nxt = found_a_r;
    found_s_nxt = found_s_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    pick_nxt    = pick_r;
    el_oct_nxt  = el_oct_r;
    el_pos_nxt  = el_pos_r;
    kind_nxt    = kind_r;
    onote_nxt   = onote_r;

    phase_cmd   = '0;
    a_we        = 1'b0;
    a_waddr     = '0;
    a_wdata     = note_r;
    a_raddr     = idx_r[IW-1:0];
    s_we        = 1'b0;
    s_waddr     = '0;
    s_wdata     = carry_r;
    s_raddr     = idx_r[IW-1:0];

    // Shared pass over the lists: issue one read a cycle, data in the next cycle
    if (state_r == ST_ON_SCAN || state_r == ST_ON_SHIFT || state_r == ST_OFF_PASS) begin
      if (issuing) begin
        idx_nxt = idx_r + CW'(1);
      end
      dv_nxt   = issuing;
      didx_nxt = idx_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = narp_op_t'(in_opcode);
          note_nxt  = in_note_number;
          k_nxt     = k_now;
          kind_nxt  = EV_NONE;
          onote_nxt = '0;
          idx_nxt   = '0;
          end_nxt   = held_r;
          case (narp_op_t'(in_opcode))
            OP_TICK: begin
              state_nxt = ST_TICK;
            end
            OP_NOTE_ON: begin
              vel_nxt   = in_velocity;
              dup_nxt   = 1'b0;
              ins_nxt   = '0;
              state_nxt = ST_ON_SCAN;
            end
            OP_NOTE_OFF: begin
              found_a_nxt = 1'b0;
              found_s_nxt = 1'b0;
              state_nxt   = ST_OFF_PASS;
            end
            OP_CLEAR: begin
              held_nxt        = '0;
              oct_nxt         = '0;
              pos_nxt         = '0;
              up_nxt          = 1'b1;
              phase_cmd.clear = 1'b1;
              state_nxt       = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // If enabled with notes held, step the phase; wraps pick the next element
      ST_TICK: begin
        state_nxt = ST_DONE;
        if (cfg_enable && held_r != '0) begin
          phase_cmd.tick_go = 1'b1;
          if (tick.gate_fire) begin
            kind_nxt = EV_GATE_OFF;
          end
          if (tick.wrap) begin
            kind_nxt   = EV_NOTE_ON;
            el_oct_nxt = eo;
            el_pos_nxt = en;
            oct_nxt    = inc_oct;
            pos_nxt    = inc_pos;
            state_nxt  = ST_ELEM_RD;
            case (narp_pattern_t'(cfg_pattern))
              PAT_DOWN: begin
                el_oct_nxt = OW'(oc - UW'(1) - UW'(eo));
                el_pos_nxt = IW'(held_r - CW'(1) - CW'(en));
              end
              PAT_UPDOWN: begin
                oct_nxt = eo;
                pos_nxt = en;
                if (len > LW'(1)) begin
                  if (up_r) begin
                    if (p_last && o_last) begin
                      up_nxt = 1'b0;
                      if (held_r >= CW'(2)) begin
                        oct_nxt = OW'(oc - UW'(1));
                        pos_nxt = IW'(held_r - CW'(2));
                      end else begin
                        oct_nxt = OW'(oc - UW'(2));
                        pos_nxt = '0;
                      end
                    end
                  end else if (k_zero) begin
                    up_nxt = 1'b1;
                    if (held_r >= CW'(2)) begin
                      oct_nxt = '0;
                      pos_nxt = IW'(1);
                    end else begin
                      oct_nxt = OW'(1);
                      pos_nxt = '0;
                    end
                  end else if (en != '0) begin
                    pos_nxt = en - IW'(1);
                  end else begin
                    oct_nxt = eo - OW'(1);
                    pos_nxt = IW'(held_r - CW'(1));
                  end
                  if (up_r && !(p_last && o_last)) begin
                    oct_nxt = inc_oct;
                    pos_nxt = inc_pos;
                  end
                end
              end
              PAT_RANDOM: begin
                lfsr_nxt  = lfsr_step;
                oct_nxt   = eo;
                pos_nxt   = en;
                rem_nxt   = prod[LFSR_W +: LW];
                q_nxt     = '0;
                pick_nxt  = 1'b1;
                state_nxt = ST_DIV;
              end
              default: begin
              end
            endcase
          end
        end
      end

      // Split a linear index into octave and position, one subtract a cycle
      ST_DIV: begin
        if (rem_r >= LW'(held_r)) begin
          rem_nxt = rem_r - LW'(held_r);
          q_nxt   = q_r + OW'(1);
        end else if (pick_r) begin
          el_oct_nxt = q_r;
          el_pos_nxt = rem_r[IW-1:0];
          state_nxt  = ST_ELEM_RD;
        end else begin
          oct_nxt   = q_r;
          pos_nxt   = rem_r[IW-1:0];
          state_nxt = ST_DONE;
        end
      end

      ST_ELEM_RD: begin
        a_raddr   = el_pos_r;
        s_raddr   = el_pos_r;
        state_nxt = ST_ELEM_DATA;
      end

      // Transpose by octave and clamp
      ST_ELEM_DATA: begin
        onote_nxt = (nsum > (NOTE_W+1)'(NOTE_TOP)) ? NOTE_W'(NOTE_TOP) : nsum[NOTE_W-1:0];
        state_nxt = ST_DONE;
      end

      // Look for a duplicate and count sorted entries not above the note
      ST_ON_SCAN: begin
        if (dv_r) begin
          if (a_rdata == note_r) begin
            dup_nxt = 1'b1;
          end
          if (s_rdata <= note_r) begin
            ins_nxt = ins_r + CW'(1);
          end
        end
        if (pass_done) begin
          if (dup_r || held_r == CW'(MAX_HELD)) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = ins_r;
            end_nxt   = held_r;
            carry_nxt = note_r;
            state_nxt = ST_ON_SHIFT;
          end
        end
      end

      // Ripple the sorted tail up by one, then append to the arrival list
      ST_ON_SHIFT: begin
        if (dv_r) begin
          s_we      = 1'b1;
          s_waddr   = didx_r[IW-1:0];
          carry_nxt = s_rdata;
        end
        if (pass_done) begin
          s_we      = 1'b1;
          s_waddr   = held_r[IW-1:0];
          a_we      = 1'b1;
          a_waddr   = held_r[IW-1:0];
          held_nxt  = held_r + CW'(1);
          state_nxt = ST_RESEAT;
        end
      end

      // Drop the note from both lists, closing the gap as the pass goes
      ST_OFF_PASS: begin
        a_wdata = a_rdata;
        s_wdata = s_rdata;
        if (dv_r) begin
          if (found_a_r) begin
            a_we    = 1'b1;
            a_waddr = didx_dec[IW-1:0];
          end
          if (found_s_r) begin
            s_we    = 1'b1;
            s_waddr = didx_dec[IW-1:0];
          end
          if (a_rdata == note_r) begin
            found_a_nxt = 1'b1;
          end
          if (s_rdata == note_r) begin
            found_s_nxt = 1'b1;
          end
        end
        if (pass_done) begin
          if (found_a_r) begin
            held_nxt = held_r - CW'(1);
          end
          state_nxt = ST_RESEAT;
        end
      end

      // Re-seat the walk position for the new list length
      ST_RESEAT: begin
        if (held_r == '0) begin
          oct_nxt   = '0;
          pos_nxt   = '0;
          phase_cmd.release_gate = (op_r == OP_NOTE_OFF);
          state_nxt = ST_DONE;
        end else if (k_r >= len) begin
          oct_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = k_r;
          q_nxt     = '0;
          pick_nxt  = 1'b0;
          state_nxt = ST_DIV;
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      oct_r   <= '0;
      pos_r   <= '0;
      up_r    <= 1'b1;
      lfsr_r  <= LFSR_SEED;
      vel_r   <= '0;
      dv_r    <= 1'b0;
      kind_r  <= EV_NONE;
      onote_r <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      oct_r   <= oct_nxt;
      pos_r   <= pos_nxt;
      up_r    <= up_nxt;
      lfsr_r  <= lfsr_nxt;
      vel_r   <= vel_nxt;
      dv_r    <= dv_nxt;
      kind_r  <= kind_nxt;
      onote_r <= onote_nxt;
    end
  end

  // Working registers of a transaction
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    note_r    <= note_nxt;
    k_r       <= k_nxt;
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    didx_r    <= didx_nxt;
    dup_r     <= dup_nxt;
    ins_r     <= ins_nxt;
    carry_r   <= carry_nxt;
    found_a_r <= found_a_nxt;
    found_s_r <= found_s_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    pick_r    <= pick_nxt;
    el_oct_r  <= el_oct_nxt;
    el_pos_r  <= el_pos_nxt;
  end

  assign busy           = state_r != ST_IDLE;
  assign out_strobe     = state_r == ST_DONE;
  assign out_event_kind = kind_r;
  assign out_note       = onote_r;
  assign out_velocity   = vel_r;

`ifndef SYNTHESIS
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(MAX_HELD))
    else $error("held count above list size");

  a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && held_r != '0) |-> (CW'(pos_r) < held_r))
    else $error("walk position outside held list");

  a_empty_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && held_r == '0) |-> (pos_r == '0 && oct_r == '0))
    else $error("walk position not zero with empty list");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
`endif

endmodule

`default_nettype wire

### design/note_arpeggiator_unit.sv
// ----------------------------------------------------------------------------
// note_arpeggiator_unit
// Arpeggiator: held note lists, pattern walk and step/gate timing.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. in_opcode selects sample tick, note on, note off or clear.
//   Every transaction yields exactly one result: out_strobe is high for one
//   cycle with out_event_kind, out_note and out_velocity. The receiver has no
//   way to hold results off; the unit never needs one.
//   Configuration: cfg_we writes cfg_data into register cfg_index (enable,
//   pattern mode, octave count, phase increment, gate length); write only
//   while busy is low.
//   The note-on and note-off cost is set by the passes over the held-list
//   memories, one entry per cycle on the single read port of each RAM, and
//   by the one-subtract-a-cycle position split.
//   Reset (rst_n low, synchronous) empties the held list and restores the
//   register defaults; the note memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module note_arpeggiator_unit import narp_pkg::*; #(
  parameter int MAX_HELD    = MAX_HELD_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [NOTE_W-1:0]      in_note_number,
  input  wire logic [NOTE_W-1:0]      in_velocity,
  output logic                        out_strobe,
  output logic [1:0]                  out_event_kind,
  output logic [NOTE_W-1:0]           out_note,
  output logic [NOTE_W-1:0]           out_velocity,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

  logic                  enable_r;
  logic [PATTERN_W-1:0]  pattern_r;
  logic [OCTAVE_W-1:0]   octaves_r;
  logic [CFG_DATA_W-1:0] phase_inc_r;
  logic [GATE_W-1:0]     gate_len_r;

  narp_phase_cmd_t       phase_cmd;
  narp_tick_t            tick;

  logic                  a_we, s_we;
  logic [IW-1:0]         a_waddr, a_raddr, s_waddr, s_raddr;
  logic [NOTE_W-1:0]     a_wdata, a_rdata, s_wdata, s_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      pattern_r   <= PAT_UP;
      octaves_r   <= OCTAVE_W'(1);
      phase_inc_r <= '0;
      gate_len_r  <= GATE_W'(32768);
    end else if (cfg_we) begin
      case (narp_reg_t'(cfg_index))
        REG_ENABLE:          enable_r    <= cfg_data[0];
        REG_PATTERN_MODE:    pattern_r   <= cfg_data[PATTERN_W-1:0];
        REG_OCTAVE_COUNT:    octaves_r   <= cfg_data[OCTAVE_W-1:0];
        REG_PHASE_INCREMENT: phase_inc_r <= cfg_data;
        REG_GATE_LENGTH:     gate_len_r  <= cfg_data[GATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  narp_ram #(.WIDTH(NOTE_W), .DEPTH(MAX_HELD)) u_arrival (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  narp_ram #(.WIDTH(NOTE_W), .DEPTH(MAX_HELD)) u_sorted (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  narp_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
    .clk             (clk),
    .rst_n           (rst_n),
    .phase_increment (phase_inc_r),
    .gate_length     (gate_len_r),
    .cmd             (phase_cmd),
    .tick            (tick)
  );

  narp_ctrl #(.MAX_HELD(MAX_HELD), .MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_note_number (in_note_number),
    .in_velocity    (in_velocity),
    .out_strobe     (out_strobe),
    .out_event_kind (out_event_kind),
    .out_note       (out_note),
    .out_velocity   (out_velocity),
    .cfg_enable     (enable_r),
    .cfg_pattern    (pattern_r),
    .cfg_octaves    (octaves_r),
    .phase_cmd      (phase_cmd),
    .tick           (tick),
    .a_we           (a_we),
    .a_waddr        (a_waddr),
    .a_wdata        (a_wdata),
    .a_raddr        (a_raddr),
    .a_rdata        (a_rdata),
    .s_we           (s_we),
    .s_waddr        (s_waddr),
    .s_wdata        (s_wdata),
    .s_raddr        (s_raddr),
    .s_rdata        (s_rdata)
  );

endmodule

`default_nettype wire

### tb/tb_note_arpeggiator_unit.sv
// ----------------------------------------------------------------------------
// tb_note_arpeggiator_unit
// Self-checking bench for the note arpeggiator. A queue-fed driver sends
// note on, note off, clear and sample tick transactions with random gaps.
// A behavioral model of the held lists, the pattern walk and the step/gate
// phases predicts each result. The monitor compares every strobed result
// field by field, in order. Configuration changes between phases, while
// the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_note_arpeggiator_unit;
  import narp_pkg::*;

  typedef struct packed {
    narp_op_t          op;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
  } arp_cmd_t;

  typedef struct packed {
    narp_event_t       kind;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
  } arp_event_t;

  localparam int HELD_MAX   = 16;
  localparam int OCT_MAX    = 4;
  localparam int WDOG_LIMIT = 4000;
  localparam longint unsigned GATE_SAT = 64'h1_FFFF_FFFF;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_opcode;
  logic [NOTE_W-1:0]      in_note_number;
  logic [NOTE_W-1:0]      in_velocity;
  logic                   out_strobe;
  logic [1:0]             out_event_kind;
  logic [NOTE_W-1:0]      out_note;
  logic [NOTE_W-1:0]      out_velocity;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  note_arpeggiator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_note_number(in_note_number),
    .in_velocity(in_velocity), .out_strobe(out_strobe),
    .out_event_kind(out_event_kind), .out_note(out_note),
    .out_velocity(out_velocity), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Pending transactions and expected results
  arp_cmd_t   cmd_q[$];
  arp_event_t event_q[$];

  int  n_errors;
  int  n_cmds;
  int  n_note_ons;
  int  n_gate_offs;
  int  idle_cycles;
  bit  no_idle;
  bit  last_accept;

  // Model state
  int unsigned     m_enable, m_pattern, m_octaves, m_gate;
  longint unsigned m_inc;
  int unsigned     m_arrival[HELD_MAX];
  int unsigned     m_sorted[HELD_MAX];
  int unsigned     m_held, m_oct_pos, m_note_pos, m_vel;
  bit              m_going_up, m_gate_closed;
  longint unsigned m_step_phase, m_gate_phase;
  logic [15:0]     m_lfsr;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned oct_used();
    if (m_octaves < 1) return 1;
    if (m_octaves > OCT_MAX) return OCT_MAX;
    return m_octaves;
  endfunction

  function automatic void set_walk(int unsigned k);
    if (m_held == 0) begin
      m_oct_pos  = 0;
      m_note_pos = 0;
    end else begin
      m_oct_pos  = k / m_held;
      m_note_pos = k % m_held;
    end
  endfunction

  function automatic int unsigned walk_pos();
    if (m_held == 0) return 0;
    return m_oct_pos * m_held + m_note_pos;
  endfunction

  // Restart the walk if the position fell off the sequence
  function automatic void reseat(int unsigned k);
    if (m_held == 0 || k >= m_held * oct_used()) set_walk(0);
    else set_walk(k);
  endfunction

  function automatic int unsigned seq_note(int unsigned k);
    int unsigned oct;
    int unsigned pos;
    int unsigned n;
    oct = k / m_held;
    pos = k % m_held;
    n = ((m_pattern == PAT_PLAYED) ? m_arrival[pos] : m_sorted[pos]) + SEMITONES * oct;
    return (n > NOTE_TOP) ? NOTE_TOP : n;
  endfunction

  function automatic int unsigned advance_walk();
    int unsigned len;
    int unsigned k;
    int unsigned n;
    len = m_held * oct_used();
    k = walk_pos();
    if (k >= len) k = 0;
    case (m_pattern)
      PAT_DOWN: begin
        n = seq_note(len - 1 - k);
        k = (k + 1) % len;
      end
      PAT_UPDOWN: begin
        n = seq_note(k);
        if (len > 1) begin
          if (m_going_up) begin
            k++;
            if (k >= len) begin
              k = len - 2;
              m_going_up = 0;
            end
          end else if (k == 0) begin
            k = 1;
            m_going_up = 1;
          end else begin
            k--;
          end
        end
      end
      PAT_RANDOM: begin
        m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[15:1]};
        n = seq_note(32'((longint'(m_lfsr) * len) >> 16));
      end
      default: begin
        n = seq_note(k);
        k = (k + 1) % len;
      end
    endcase
    set_walk(k);
    return n;
  endfunction

  function automatic void add_note(int unsigned n);
    int unsigned k;
    int i;
    int j;
    k = walk_pos();
    for (i = 0; i < m_held; i++) if (m_arrival[i] == n) return;
    if (m_held >= HELD_MAX) return;
    m_arrival[m_held] = n;
    for (i = 0; i < m_held && m_sorted[i] <= n; i++) begin end
    for (j = m_held; j > i; j--) m_sorted[j] = m_sorted[j-1];
    m_sorted[i] = n;
    m_held++;
    reseat(k);
  endfunction

  function automatic void drop_note(int unsigned n);
    int unsigned k;
    int i;
    int j;
    int pa;
    int ps;
    k = walk_pos();
    pa = -1;
    ps = -1;
    for (i = 0; i < m_held; i++) begin
      if (pa < 0 && m_arrival[i] == n) pa = i;
      if (ps < 0 && m_sorted[i] == n) ps = i;
    end
    if (pa >= 0) begin
      for (j = pa; j + 1 < m_held; j++) m_arrival[j] = m_arrival[j+1];
      for (j = ps; j + 1 < m_held; j++) m_sorted[j] = m_sorted[j+1];
      m_held--;
    end
    if (m_held == 0) begin
      set_walk(0);
      m_gate_closed = 0;
    end else begin
      reseat(k);
    end
  endfunction

  // Predict the result of one accepted transaction
  function automatic arp_event_t arp_predict(arp_cmd_t c);
    arp_event_t e;
    longint unsigned sum;
    e.kind = EV_NONE;
    e.note = '0;
    case (c.op)
      OP_NOTE_ON: begin
        m_vel = c.vel;
        add_note(c.note);
      end
      OP_NOTE_OFF: drop_note(c.note);
      OP_CLEAR: begin
        m_held = 0;
        set_walk(0);
        m_step_phase = 0;
        m_gate_phase = 0;
        m_gate_closed = 0;
        m_going_up = 1;
      end
      default: begin
        if (m_enable != 0 && m_held != 0) begin
          sum = m_step_phase + m_inc;
          m_gate_phase += m_inc;
          if (m_gate_phase > GATE_SAT) m_gate_phase = GATE_SAT;
          if (sum > 64'hFFFF_FFFF) begin
            m_step_phase = sum & 64'hFFFF_FFFF;
            m_gate_phase = 0;
            m_gate_closed = 0;
            e.note = NOTE_W'(advance_walk());
            e.kind = EV_NOTE_ON;
          end else begin
            m_step_phase = sum;
            if (!m_gate_closed && m_gate < 65536 &&
                m_gate_phase >= (longint'(m_gate) << 16)) begin
              m_gate_closed = 1;
              e.kind = EV_GATE_OFF;
            end
          end
        end
      end
    endcase
    e.vel = NOTE_W'(m_vel);
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Monitor: check strobed results, then predict newly accepted transactions
  always @(posedge clk) begin
    arp_event_t want;
    arp_cmd_t   c;
    last_accept <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_strobe) begin
        if (event_q.size() == 0) begin
          report_mismatch("unexpected result, kind", out_event_kind, -1);
        end else begin
          want = event_q.pop_front();
          if (out_event_kind !== want.kind)
            report_mismatch("event_kind", out_event_kind, want.kind);
          if (out_note !== want.note) report_mismatch("out_note", out_note, want.note);
          if (out_velocity !== want.vel)
            report_mismatch("out_velocity", out_velocity, want.vel);
          if (want.kind == EV_NOTE_ON) n_note_ons++;
          if (want.kind == EV_GATE_OFF) n_gate_offs++;
        end
      end
      if (start && !busy) begin
        c.op   = narp_op_t'(in_opcode);
        c.note = in_note_number;
        c.vel  = in_velocity;
        event_q = {event_q, arp_predict(c)};
        n_cmds++;
      end
    end
  end

  // Driver: hold a transaction until taken, then idle or load the next one
  always @(negedge clk) begin
    arp_cmd_t c;
    if (rst_n && (!start || last_accept)) begin
      if (cmd_q.size() == 0 || (!no_idle && $urandom_range(99) < 16)) begin
        start <= 1'b0;
      end else begin
        c = cmd_q.pop_front();
        start          <= 1'b1;
        in_opcode      <= c.op;
        in_note_number <= c.note;
        in_velocity    <= c.vel;
      end
    end
  end

  // Watchdog: stop a run that makes no progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
      $display("tb_note_arpeggiator_unit failed");
      $finish;
    end
  end

  task automatic push_cmd(narp_op_t op, int unsigned note, int unsigned vel);
    arp_cmd_t c;
    c.op   = op;
    c.note = NOTE_W'(note);
    c.vel  = NOTE_W'(vel);
    cmd_q = {cmd_q, c};
  endtask

  // Wait until every transaction is taken and answered, then let the unit settle
  task automatic drain();
    do @(posedge clk);
    while (cmd_q.size() != 0 || start || event_q.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(narp_reg_t idx, longint unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[31:0];
    case (idx)
      REG_ENABLE:          m_enable  = 32'(val & 1);
      REG_PATTERN_MODE:    m_pattern = 32'(val & 7);
      REG_OCTAVE_COUNT:    m_octaves = 32'(val & 7);
      REG_PHASE_INCREMENT: m_inc     = val & 64'hFFFF_FFFF;
      REG_GATE_LENGTH:     m_gate    = 32'(val & 32'h1FFFF);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int unsigned en, int unsigned pat, int unsigned oct,
                            longint unsigned inc, int unsigned gate);
    write_reg(REG_ENABLE, en);
    write_reg(REG_PATTERN_MODE, pat);
    write_reg(REG_OCTAVE_COUNT, oct);
    write_reg(REG_PHASE_INCREMENT, inc);
    write_reg(REG_GATE_LENGTH, gate);
  endtask

  task automatic random_phase(int count, int on_pct, int wide_pct);
    int r;
    int unsigned n;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      n = ($urandom_range(99) < wide_pct) ? $urandom_range(127) : 40 + $urandom_range(19);
      if (r < 97 - on_pct - 15) push_cmd(OP_TICK, $urandom_range(127), $urandom_range(127));
      else if (r < 97 - 15) push_cmd(OP_NOTE_ON, n, $urandom_range(127));
      else if (r < 97) push_cmd(OP_NOTE_OFF, n, $urandom_range(127));
      else push_cmd(OP_CLEAR, $urandom_range(127), $urandom_range(127));
    end
  endtask

  initial begin
    longint unsigned inc;
    int unsigned gate;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_TICK;
    in_note_number = '0;
    in_velocity = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    n_errors = 0;
    n_cmds = 0;
    n_note_ons = 0;
    n_gate_offs = 0;
    no_idle = 0;
    m_enable = 0;
    m_pattern = PAT_UP;
    m_octaves = 1;
    m_inc = 0;
    m_gate = 32768;
    m_held = 0;
    m_oct_pos = 0;
    m_note_pos = 0;
    m_going_up = 1;
    m_step_phase = 0;
    m_gate_phase = 0;
    m_gate_closed = 0;
    m_vel = 0;
    m_lfsr = LFSR_SEED;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: disabled ticks, extremes, duplicates, stray note off, last release
    push_cmd(OP_TICK, 0, 0);
    push_cmd(OP_NOTE_ON, 127, 127);
    push_cmd(OP_TICK, 127, 127);
    push_cmd(OP_NOTE_ON, 0, 0);
    push_cmd(OP_NOTE_ON, 127, 5);
    push_cmd(OP_NOTE_OFF, 64, 0);
    drain();
    set_config(1, PAT_UP, 4, 64'h8000_0000, 0);
    for (int i = 0; i < 6; i++) push_cmd(OP_TICK, 0, 0);
    push_cmd(OP_NOTE_OFF, 127, 0);
    push_cmd(OP_NOTE_OFF, 0, 0);
    push_cmd(OP_TICK, 0, 0);
    push_cmd(OP_NOTE_ON, 60, 100);
    for (int i = 0; i < 3; i++) push_cmd(OP_TICK, 0, 0);
    push_cmd(OP_CLEAR, 0, 0);
    push_cmd(OP_TICK, 0, 0);
    drain();

    // Fill past the list size with a no-gate-off, all-ones increment
    set_config(1, PAT_UPDOWN, 0, 64'hFFFF_FFFF, 65536);
    for (int i = 0; i < 18; i++) push_cmd(OP_NOTE_ON, 100 + i, i);
    for (int i = 0; i < 12; i++) push_cmd(OP_TICK, 0, 0);
    drain();

    // Random phases over the pattern modes and register extremes
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(4))
        0: inc = 64'hFFFF_FFFF;
        1: inc = 64'h8000_0000 >> $urandom_range(3);
        2: inc = $urandom();
        3: inc = 64'h1_0000_0000 / (2 + $urandom_range(6));
        default: inc = (p == 5) ? 0 : $urandom();
      endcase
      case ($urandom_range(3))
        0: gate = 0;
        1: gate = 65536;
        2: gate = 65535;
        default: gate = $urandom_range(131071);
      endcase
      no_idle = (p == 3 || p == 4);
      set_config((p == 7) ? 0 : 1, p % 8, (p < 8) ? p % 5 : $urandom_range(7), inc, gate);
      random_phase(80, (p % 3 == 0) ? 40 : 20, (p % 2) ? 40 : 10);
      drain();
    end

    $display("covered %0d transactions: %0d note-on and %0d gate-off events checked",
             n_cmds, n_note_ons, n_gate_offs);
    if (n_errors == 0) begin
      $display("tb_note_arpeggiator_unit passed");
    end else begin
      $display("mismatches: %0d", n_errors);
      $display("tb_note_arpeggiator_unit failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/narp_pkg.sv
design/narp_ram.sv
design/narp_phase.sv
design/narp_ctrl.sv
design/note_arpeggiator_unit.sv
tb/tb_note_arpeggiator_unit.sv
